[src/jhd_pkg.sv]
`timescale 1ns / 1ps
package jhd_pkg;

	localparam int SYMBOL_DEPTH = 256;
	localparam int SYM_AW = 9;
	localparam int QNT_AW = 6;
	localparam logic [7:0] BYTE_FF = 8'hff;
	localparam logic [6:0] COEF_END = 7'd64;
	localparam logic [4:0] CODE_MAX = 5'd16;
	localparam logic [7:0] DC_SIZE_MAX = 8'd11;
	localparam logic [3:0] AC_SIZE_MAX = 4'd10;

	typedef enum logic [2:0] {
		MODE_COUNT = 3'd0,
		MODE_SYMBOL = 3'd1,
		MODE_QUANT = 3'd2,
		MODE_SCAN = 3'd3,
		MODE_START = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_COEF = 2'd0,
		KIND_END = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_DC_CODE = 2'd0,
		PH_DC_MAG = 2'd1,
		PH_AC_CODE = 2'd2,
		PH_AC_MAG = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_RECALC,
		ST_SYM,
		ST_QNT,
		ST_ENDB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] position;
		logic [23:0] coefficient;
	} result_t;

	typedef struct packed {
		logic emit_req;
		logic item_end;
	} out_ctl_t;

	localparam logic [5:0] NATURAL_OF_ZIGZAG [64] = '{
		6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

endpackage

[src/jhd_ram.sv]
`timescale 1ns / 1ps
module jhd_ram #(
	parameter int AW = 6,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[src/jhd_out.sv]
`timescale 1ns / 1ps
module jhd_out (
	input  logic               clk,
	input  logic               arst_n,
	input  jhd_pkg::out_ctl_t  ctl,
	input  jhd_pkg::result_t   res,
	output logic               can_emit,
	output logic               pend_valid,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [31:0]        m_axis_tdata,
	output logic [1:0]         m_axis_tuser,
	output logic               m_axis_tlast
);
	jhd_pkg::result_t pend_q;
	jhd_pkg::result_t out_q;
	logic pend_v_q;
	logic out_v_q;
	logic last_q;
	logic out_free;

	assign out_free = !out_v_q || m_axis_tready;
	assign can_emit = !pend_v_q || out_free;
	assign pend_valid = pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (ctl.emit_req && can_emit) begin
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
				pend_v_q <= 1'b1;
			end else if (ctl.item_end && can_emit && pend_v_q) begin
				out_v_q <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_req && can_emit) begin
			pend_q <= res;
			if (pend_v_q) begin
				out_q <= pend_q;
				last_q <= 1'b0;
			end
		end else if (ctl.item_end && can_emit && pend_v_q) begin
			out_q <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {2'b00, out_q.coefficient, out_q.position};
	assign m_axis_tuser = out_q.kind;
	assign m_axis_tlast = last_q;
endmodule

[src/jhd_core.sv]
`timescale 1ns / 1ps
module jhd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         in_mode,
	input  logic               in_cls,
	input  logic [7:0]         in_index,
	input  logic [7:0]         in_value,
	input  logic [15:0]        blk_limit,
	input  logic               can_emit,
	output jhd_pkg::out_ctl_t  ctl,
	output jhd_pkg::result_t   res
);
	jhd_pkg::state_t state_q, state_d;
	jhd_pkg::phase_t phase_q;
	logic [7:0] counts_q [32];
	logic [15:0] acc_q;
	logic [4:0] len_q;
	logic [25:0] first_q;
	logic [11:0] offset_q;
	logic dirty_q;
	logic [10:0] mb_q;
	logic [3:0] left_q;
	logic [3:0] msize_q;
	logic [6:0] ci_q;
	logic [15:0] pred_q;
	logic [15:0] rcd_q;
	logic ff_q;
	logic [7:0] sh_q;
	logic [3:0] bl_q;
	logic signed [16:0] mv_q;
	logic qdc_q;
	logic [5:0] qpos_q;
	logic [4:0] j_q;

	logic accept, is_code, cls, bitv, feed;
	logic [7:0] byte_v;
	logic [4:0] cidx;
	logic [7:0] cnt;
	logic [15:0] acc_n;
	logic [4:0] len_n;
	logic [25:0] diff;
	logic hit;
	logic [12:0] k;
	logic [10:0] mb_n;
	logic [3:0] left_n;
	logic [11:0] full;
	logic signed [16:0] v;
	logic [15:0] pred_n;
	logic [7:0] sym_rdata, q_rdata, sym;
	logic sym_re, q_re;
	logic [jhd_pkg::SYM_AW-1:0] sym_raddr;
	logic [jhd_pkg::QNT_AW-1:0] q_raddr;
	logic signed [25:0] prod;
	logic [6:0] ci_inc, ci_skip;
	logic [16:0] rcd_n;
	logic more;
	logic more_bits;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == jhd_pkg::ST_IDLE);
	assign is_code = (phase_q == jhd_pkg::PH_DC_CODE) || (phase_q == jhd_pkg::PH_AC_CODE);
	assign cls = (phase_q == jhd_pkg::PH_AC_CODE);
	assign bitv = sh_q[7];
	assign cidx = (state_q == jhd_pkg::ST_RECALC) ? {cls, j_q[3:0]} : {cls, len_q[3:0]};
	assign cnt = counts_q[cidx];
	assign acc_n = {acc_q[14:0], bitv};
	assign len_n = len_q + 5'd1;
	assign diff = {10'd0, acc_n} - first_q;
	assign hit = ({10'd0, acc_n} >= first_q) && (diff < {18'd0, cnt});
	assign k = {1'b0, offset_q} + {5'd0, diff[7:0]};
	assign mb_n = {mb_q[9:0], bitv};
	assign left_n = left_q - 4'd1;
	assign full = (12'd1 << msize_q) - 12'd1;
	assign v = (mb_n < full[11:1] + 11'd1) ?
		($signed({6'd0, mb_n}) - $signed({5'd0, full})) : $signed({6'd0, mb_n});
	assign pred_n = pred_q + v[15:0];
	assign sym = sym_rdata;
	assign prod = mv_q * $signed({1'b0, q_rdata});
	assign ci_inc = ci_q + 7'd1;
	assign ci_skip = ci_q + 7'd16;
	assign rcd_n = {1'b0, rcd_q} + 17'd1;
	assign more = (bl_q != 4'd0);
	assign more_bits = (bl_q > 4'd1);

	always_comb begin
		byte_v = in_value;
		feed = 1'b0;
		if (ff_q) begin
			if (in_value == 8'd0) begin
				feed = 1'b1;
				byte_v = jhd_pkg::BYTE_FF;
			end
		end else if (in_value != jhd_pkg::BYTE_FF) begin
			feed = 1'b1;
		end
	end

	jhd_ram #(.AW(jhd_pkg::SYM_AW), .DW(8)) u_sym (
		.clk(clk),
		.we(accept && in_mode == jhd_pkg::MODE_SYMBOL && {1'b0, in_index} < 9'(jhd_pkg::SYMBOL_DEPTH)),
		.waddr({in_cls, in_index}),
		.wdata(in_value),
		.re(sym_re),
		.raddr(sym_raddr),
		.rdata(sym_rdata)
	);

	jhd_ram #(.AW(jhd_pkg::QNT_AW), .DW(8)) u_qnt (
		.clk(clk),
		.we(accept && in_mode == jhd_pkg::MODE_QUANT && in_index < 8'd64),
		.waddr(in_index[5:0]),
		.wdata(in_value),
		.re(q_re),
		.raddr(q_raddr),
		.rdata(q_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jhd_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (in_mode == jhd_pkg::MODE_SCAN && feed) ?
						jhd_pkg::ST_BIT : jhd_pkg::ST_DONE;
				end
			end
			jhd_pkg::ST_BIT: begin
				if (can_emit) begin
					if (dirty_q) begin
						state_d = jhd_pkg::ST_RECALC;
					end else if (is_code) begin
						if (hit && k < 13'(jhd_pkg::SYMBOL_DEPTH)) begin
							state_d = jhd_pkg::ST_SYM;
						end else if (!hit && len_n < jhd_pkg::CODE_MAX) begin
							state_d = more_bits ? jhd_pkg::ST_BIT : jhd_pkg::ST_DONE;
						end else begin
							state_d = more_bits ? jhd_pkg::ST_BIT : jhd_pkg::ST_DONE;
						end
					end else if (left_n != 4'd0) begin
						state_d = more_bits ? jhd_pkg::ST_BIT : jhd_pkg::ST_DONE;
					end else if (phase_q == jhd_pkg::PH_DC_MAG || ci_q < jhd_pkg::COEF_END) begin
						state_d = jhd_pkg::ST_QNT;
					end else begin
						state_d = jhd_pkg::ST_ENDB;
					end
				end
			end
			jhd_pkg::ST_RECALC: begin
				if (j_q + 5'd1 >= len_q) begin
					state_d = jhd_pkg::ST_BIT;
				end
			end
			jhd_pkg::ST_SYM: begin
				if (can_emit) begin
					if (cls) begin
						if (sym == 8'd0) begin
							state_d = jhd_pkg::ST_ENDB;
						end else if (sym[3:0] == 4'd0 && ci_skip >= jhd_pkg::COEF_END) begin
							state_d = jhd_pkg::ST_ENDB;
						end else begin
							state_d = more ? jhd_pkg::ST_BIT : jhd_pkg::ST_DONE;
						end
					end else if (sym == 8'd0) begin
						state_d = jhd_pkg::ST_QNT;
					end else begin
						state_d = more ? jhd_pkg::ST_BIT : jhd_pkg::ST_DONE;
					end
				end
			end
			jhd_pkg::ST_QNT: begin
				if (can_emit) begin
					if (!qdc_q && ci_inc >= jhd_pkg::COEF_END) begin
						state_d = jhd_pkg::ST_ENDB;
					end else begin
						state_d = more ? jhd_pkg::ST_BIT : jhd_pkg::ST_DONE;
					end
				end
			end
			jhd_pkg::ST_ENDB: begin
				if (can_emit) begin
					if (blk_limit != 16'd0 && rcd_n >= {1'b0, blk_limit}) begin
						state_d = jhd_pkg::ST_DONE;
					end else begin
						state_d = more ? jhd_pkg::ST_BIT : jhd_pkg::ST_DONE;
					end
				end
			end
			jhd_pkg::ST_DONE: begin
				if (can_emit) begin
					state_d = jhd_pkg::ST_IDLE;
				end
			end
			default: state_d = jhd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.emit_req = 1'b0;
		ctl.item_end = (state_q == jhd_pkg::ST_DONE);
		res.kind = jhd_pkg::KIND_ERR;
		res.position = 6'd0;
		res.coefficient = 24'd0;
		sym_re = 1'b0;
		sym_raddr = {cls, k[7:0]};
		q_re = 1'b0;
		q_raddr = ci_q[5:0];
		unique case (state_q)
			jhd_pkg::ST_BIT: begin
				if (can_emit && !dirty_q) begin
					if (is_code) begin
						if (hit && k < 13'(jhd_pkg::SYMBOL_DEPTH)) begin
							sym_re = 1'b1;
						end else if (hit || len_n >= jhd_pkg::CODE_MAX) begin
							ctl.emit_req = 1'b1;
						end
					end else if (left_n == 4'd0) begin
						q_re = 1'b1;
						q_raddr = (phase_q == jhd_pkg::PH_DC_MAG) ? 6'd0 : ci_q[5:0];
					end
				end
			end
			jhd_pkg::ST_SYM: begin
				if (can_emit) begin
					if (cls) begin
						if (sym != 8'd0 && sym[3:0] != 4'd0 && sym[3:0] > jhd_pkg::AC_SIZE_MAX) begin
							ctl.emit_req = 1'b1;
						end
					end else if (sym > jhd_pkg::DC_SIZE_MAX) begin
						ctl.emit_req = 1'b1;
					end else if (sym == 8'd0) begin
						q_re = 1'b1;
						q_raddr = 6'd0;
					end
				end
			end
			jhd_pkg::ST_QNT: begin
				ctl.emit_req = can_emit;
				res.kind = jhd_pkg::KIND_COEF;
				res.position = qpos_q;
				res.coefficient = prod[23:0];
			end
			jhd_pkg::ST_ENDB: begin
				ctl.emit_req = can_emit;
				res.kind = jhd_pkg::KIND_END;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jhd_pkg::ST_IDLE;
			phase_q <= jhd_pkg::PH_DC_CODE;
			for (int i = 0; i < 32; i++) begin
				counts_q[i] <= 8'd0;
			end
			acc_q <= 16'd0;
			len_q <= 5'd0;
			first_q <= 26'd0;
			offset_q <= 12'd0;
			dirty_q <= 1'b0;
			mb_q <= 11'd0;
			left_q <= 4'd0;
			msize_q <= 4'd0;
			ci_q <= 7'd0;
			pred_q <= 16'd0;
			rcd_q <= 16'd0;
			ff_q <= 1'b0;
			sh_q <= 8'd0;
			bl_q <= 4'd0;
			mv_q <= 17'sd0;
			qdc_q <= 1'b0;
			qpos_q <= 6'd0;
			j_q <= 5'd0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				jhd_pkg::ST_IDLE: begin
					if (accept) begin
						if (in_mode == jhd_pkg::MODE_COUNT && in_index < 8'd16) begin
							counts_q[{in_cls, in_index[3:0]}] <= in_value;
							if (len_q != 5'd0) begin
								dirty_q <= 1'b1;
							end
						end
						if (in_mode == jhd_pkg::MODE_START) begin
							pred_q <= 16'd0;
							rcd_q <= 16'd0;
							ff_q <= 1'b0;
							phase_q <= jhd_pkg::PH_DC_CODE;
							ci_q <= 7'd0;
							acc_q <= 16'd0;
							len_q <= 5'd0;
							first_q <= 26'd0;
							offset_q <= 12'd0;
							dirty_q <= 1'b0;
							mb_q <= 11'd0;
							left_q <= 4'd0;
							msize_q <= 4'd0;
						end
						if (in_mode == jhd_pkg::MODE_SCAN) begin
							ff_q <= !ff_q && in_value == jhd_pkg::BYTE_FF;
							sh_q <= byte_v;
							bl_q <= 4'd8;
						end
					end
				end
				jhd_pkg::ST_BIT: begin
					if (can_emit) begin
						if (dirty_q) begin
							first_q <= 26'd0;
							offset_q <= 12'd0;
							j_q <= 5'd0;
						end else begin
							sh_q <= {sh_q[6:0], 1'b0};
							bl_q <= bl_q - 4'd1;
							if (is_code) begin
								if (hit || len_n >= jhd_pkg::CODE_MAX) begin
									acc_q <= 16'd0;
									len_q <= 5'd0;
									first_q <= 26'd0;
									offset_q <= 12'd0;
									if (!(hit && k < 13'(jhd_pkg::SYMBOL_DEPTH))) begin
										phase_q <= jhd_pkg::PH_DC_CODE;
										ci_q <= 7'd0;
										mb_q <= 11'd0;
										left_q <= 4'd0;
										msize_q <= 4'd0;
									end
								end else begin
									acc_q <= acc_n;
									len_q <= len_n;
									first_q <= (first_q + {18'd0, cnt}) << 1;
									offset_q <= offset_q + {4'd0, cnt};
								end
							end else begin
								mb_q <= mb_n;
								left_q <= left_n;
								if (left_n == 4'd0) begin
									qdc_q <= (phase_q == jhd_pkg::PH_DC_MAG);
									if (phase_q == jhd_pkg::PH_DC_MAG) begin
										pred_q <= pred_n;
										mv_q <= $signed({pred_n[15], pred_n});
										qpos_q <= 6'd0;
									end else begin
										mv_q <= v;
										qpos_q <= jhd_pkg::NATURAL_OF_ZIGZAG[ci_q[5:0]];
									end
								end
							end
						end
					end
				end
				jhd_pkg::ST_RECALC: begin
					first_q <= (first_q + {18'd0, cnt}) << 1;
					offset_q <= offset_q + {4'd0, cnt};
					j_q <= j_q + 5'd1;
					if (j_q + 5'd1 >= len_q) begin
						dirty_q <= 1'b0;
					end
				end
				jhd_pkg::ST_SYM: begin
					if (can_emit) begin
						if (cls) begin
							if (sym != 8'd0) begin
								if (sym[3:0] == 4'd0) begin
									ci_q <= ci_skip;
								end else if (sym[3:0] > jhd_pkg::AC_SIZE_MAX) begin
									phase_q <= jhd_pkg::PH_DC_CODE;
									ci_q <= 7'd0;
								end else begin
									ci_q <= ci_q + {3'd0, sym[7:4]};
									msize_q <= sym[3:0];
									left_q <= sym[3:0];
									mb_q <= 11'd0;
									phase_q <= jhd_pkg::PH_AC_MAG;
								end
							end
						end else if (sym > jhd_pkg::DC_SIZE_MAX) begin
							phase_q <= jhd_pkg::PH_DC_CODE;
							ci_q <= 7'd0;
						end else if (sym == 8'd0) begin
							qdc_q <= 1'b1;
							mv_q <= $signed({pred_q[15], pred_q});
							qpos_q <= 6'd0;
						end else begin
							msize_q <= sym[3:0];
							left_q <= sym[3:0];
							mb_q <= 11'd0;
							phase_q <= jhd_pkg::PH_DC_MAG;
						end
					end
				end
				jhd_pkg::ST_QNT: begin
					if (can_emit) begin
						phase_q <= jhd_pkg::PH_AC_CODE;
						ci_q <= qdc_q ? 7'd1 : ci_inc;
					end
				end
				jhd_pkg::ST_ENDB: begin
					if (can_emit) begin
						phase_q <= jhd_pkg::PH_DC_CODE;
						ci_q <= 7'd0;
						acc_q <= 16'd0;
						len_q <= 5'd0;
						first_q <= 26'd0;
						offset_q <= 12'd0;
						mb_q <= 11'd0;
						left_q <= 4'd0;
						msize_q <= 4'd0;
						if (blk_limit != 16'd0) begin
							if (rcd_n >= {1'b0, blk_limit}) begin
								rcd_q <= 16'd0;
								pred_q <= 16'd0;
							end else begin
								rcd_q <= rcd_n[15:0];
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

[src/jpeg_huffman_block_decoder_unit.sv]
`timescale 1ns / 1ps
// Baseline JPEG grayscale entropy decoder, Huffman table 0.
// Input stream (s_axis): mode in tuser selects a code count, symbol or
// quantizer load, a scan byte or a scan start; index and value in tdata.
// Output stream (m_axis): one word per result: coefficient, block end or
// invalid code in tuser, natural position and dequantized coefficient in
// tdata, tlast on the final result of an input word.
// cfg: blocks between restarts, to be written by the user only while the
// decoder is idle; the block leaves this check to the user. Items are
// taken one at a time. A load or scan start passes the done state. A scan
// byte passes the bit state per bit, a symbol read state per decoded code,
// a quantizer read/multiply state per coefficient, a block-end state per
// block end and the done state. Symbols and quantizer steps live in
// single-port-read RAMs with a registered read, which gives each code and
// coefficient its own read state. A count load in the middle of a code
// makes the next scan byte first recompute the code bounds over the code
// bits so far. Reset clears counts, predictor, decode state and the output
// register; symbol and quantizer RAMs keep their contents until written.
// When the receiver stalls, one result waits in the output register and
// one more is held internally; decoding then pauses until room frees up.
module jpeg_huffman_block_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // index[7:0], value[15:8]
	input  logic [3:0]  s_axis_tuser,   // mode[2:0], table_class[3]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // position[5:0], coefficient[29:6], zero pad
	output logic [1:0]  m_axis_tuser,   // kind[1:0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	logic [15:0] blk_limit_q;
	logic can_emit;
	logic pend_valid;
	jhd_pkg::out_ctl_t ctl;
	jhd_pkg::result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_limit_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			blk_limit_q <= cfg_data;
		end
	end

	jhd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_mode(s_axis_tuser[2:0]),
		.in_cls(s_axis_tuser[3]),
		.in_index(s_axis_tdata[7:0]),
		.in_value(s_axis_tdata[15:8]),
		.blk_limit(blk_limit_q),
		.can_emit(can_emit),
		.ctl(ctl),
		.res(res)
	);

	jhd_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.res(res),
		.can_emit(can_emit),
		.pend_valid(pend_valid),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

`ifndef SYNTH
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !pend_valid)
		else $error("input taken while a result is held");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.item_end && can_emit) |=> s_axis_tready)
		else $error("decoder did not return to idle after an item");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !ctl.emit_req)
		else $error("result produced while idle");
`endif
endmodule

[tb/sv/tb_jpeg_huffman_block_decoder_unit.sv]
`timescale 1ns / 1ps
module tb_jpeg_huffman_block_decoder_unit;
	import jhd_pkg::*;

	typedef struct {
		logic [2:0] mode;
		logic       cls;
		logic [7:0] idx;
		logic [7:0] val;
	} word_s;

	typedef struct {
		logic [1:0]  kind;
		logic [5:0]  pos;
		logic [23:0] coef;
		logic        last;
	} coef_s;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 0;
	logic [3:0]  s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 0;

	jpeg_huffman_block_decoder_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	word_s pending_q[$];
	coef_s coef_q[$];
	int    send_idle = 0;
	int    recv_stall = 0;
	int    fails = 0;
	int    cycles = 0;
	logic  in_fire = 0;

	// decoder mirror
	logic [7:0]  m_counts [2][16];
	logic [7:0]  m_syms [2][256];
	logic [7:0]  m_quant [64];
	logic [15:0] m_ri;
	logic [15:0] m_pred;
	logic [15:0] m_acc;
	int          m_len;
	logic [10:0] m_mbits;
	int          m_mleft;
	int          m_msize;
	int          m_coef;
	phase_t      m_phase;
	logic [15:0] m_rcount;
	logic        m_ff;

	function automatic void clear_block();
		m_phase = PH_DC_CODE;
		m_coef = 0;
		m_acc = 0;
		m_len = 0;
		m_mbits = 0;
		m_mleft = 0;
		m_msize = 0;
	endfunction

	function automatic void add_coef(kind_t k, int pos, int c);
		coef_s r;
		r.kind = k;
		r.pos = pos[5:0];
		r.coef = c[23:0];
		r.last = 0;
		coef_q.insert(coef_q.size(), r);
	endfunction

	function automatic bit close_block();
		add_coef(KIND_END, 0, 0);
		clear_block();
		if (m_ri != 0) begin
			m_rcount = m_rcount + 1;
			if (m_rcount >= m_ri) begin
				m_rcount = 0;
				m_pred = 0;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void code_fault();
		add_coef(KIND_ERR, 0, 0);
		clear_block();
	endfunction

	function automatic int match_code(int cls, output logic [7:0] sym);
		int unsigned first = 0, offset = 0, n, k;
		sym = 0;
		for (int l = 1; l <= m_len; l++) begin
			n = m_counts[cls][l-1];
			if (l == m_len && int'(m_acc) >= first && int'(m_acc) - first < n) begin
				k = offset + (m_acc - first);
				if (k >= SYMBOL_DEPTH) return 2;
				sym = m_syms[cls][k];
				return 1;
			end
			first = (first + n) << 1;
			offset += n;
		end
		return (m_len >= 16) ? 2 : 0;
	endfunction

	function automatic void start_mag(int size, phase_t ph);
		m_msize = size;
		m_mleft = size;
		m_mbits = 0;
		m_phase = ph;
	endfunction

	function automatic void dc_done(int diff);
		logic signed [15:0] p;
		m_pred = m_pred + diff[15:0];
		p = m_pred;
		add_coef(KIND_COEF, 0, int'(p) * int'(m_quant[0]));
		m_coef = 1;
		m_phase = PH_AC_CODE;
	endfunction

	function automatic bit decode_bit(logic b);
		logic [7:0] sym;
		int r, cls, v, half;
		if (m_phase == PH_DC_CODE || m_phase == PH_AC_CODE) begin
			cls = (m_phase == PH_AC_CODE);
			m_acc = {m_acc[14:0], b};
			m_len++;
			r = match_code(cls, sym);
			if (r == 0) return 0;
			if (r == 2) begin
				code_fault();
				return 0;
			end
			m_acc = 0;
			m_len = 0;
			if (cls == 0) begin
				if (sym > DC_SIZE_MAX) code_fault();
				else if (sym == 0) dc_done(0);
				else start_mag(sym, PH_DC_MAG);
				return 0;
			end
			if (sym == 0) return close_block();
			if (sym[3:0] == 0) begin
				m_coef += 16;
				if (m_coef >= 64) return close_block();
				return 0;
			end
			if (sym[3:0] > AC_SIZE_MAX) begin
				code_fault();
				return 0;
			end
			m_coef += sym[7:4];
			start_mag(sym[3:0], PH_AC_MAG);
			return 0;
		end
		m_mbits = {m_mbits[9:0], b};
		m_mleft--;
		if (m_mleft != 0) return 0;
		half = 1 << (m_msize - 1);
		v = m_mbits;
		if (v < half) v -= 2 * half - 1;
		if (m_phase == PH_DC_MAG) begin
			dc_done(v);
			return 0;
		end
		if (m_coef < 64) begin
			add_coef(KIND_COEF, NATURAL_OF_ZIGZAG[m_coef], v * int'(m_quant[m_coef]));
			m_coef++;
		end
		if (m_coef >= 64) return close_block();
		m_phase = PH_AC_CODE;
		return 0;
	endfunction

	function automatic void predict_word(word_s w);
		int n_prev;
		logic [7:0] v;
		bit feed;
		n_prev = coef_q.size();
		v = w.val;
		feed = 0;
		case (w.mode)
			MODE_COUNT: if (w.idx < 16) m_counts[w.cls][w.idx] = v;
			MODE_SYMBOL: m_syms[w.cls][w.idx] = v;
			MODE_QUANT: if (w.idx < 64) m_quant[w.idx] = v;
			MODE_START: begin
				m_pred = 0;
				m_rcount = 0;
				m_ff = 0;
				clear_block();
			end
			MODE_SCAN: begin
				if (m_ff) begin
					m_ff = 0;
					if (v == 0) begin
						v = BYTE_FF;
						feed = 1;
					end
				end else if (v == BYTE_FF) m_ff = 1;
				else feed = 1;
				if (feed)
					for (int b = 7; b >= 0; b--)
						if (decode_bit(v[b])) break;
			end
			default: ;
		endcase
		if (coef_q.size() > n_prev) coef_q[$].last = 1;
	endfunction

	function automatic void send_word(logic [2:0] mode, logic cls, logic [7:0] idx,
			logic [7:0] val);
		word_s w;
		w.mode = mode;
		w.cls = cls;
		w.idx = idx;
		w.val = val;
		pending_q.insert(pending_q.size(), w);
		predict_word(w);
	endfunction

	// encoder side
	int  enc_code [2][32];
	int  enc_len [2][32];
	int  nsyms [2];
	int  enc_blocks;
	bit  bitq[$];
	logic [7:0] dc_list [13] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12};
	logic [7:0] ac_list [29] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h21, 8'h05,
		8'h12, 8'h31, 8'h0a, 8'h41, 8'h06, 8'h13, 8'h51, 8'h61, 8'hf0, 8'h22, 8'h07,
		8'h71, 8'h09, 8'h81, 8'h32, 8'hf5, 8'h10, 8'h0b, 8'ha1, 8'h08, 8'he3};
	int dc_cnt [16] = '{0, 0, 5, 3, 2, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	int ac_cnt [16] = '{0, 1, 2, 3, 4, 5, 6, 8, 0, 0, 0, 0, 0, 0, 0, 0};

	function automatic void build_codes(int cls);
		int code = 0, k = 0, n;
		for (int l = 1; l <= 16; l++) begin
			n = cls ? ac_cnt[l-1] : dc_cnt[l-1];
			for (int j = 0; j < n; j++) begin
				enc_code[cls][k] = code;
				enc_len[cls][k] = l;
				code++;
				k++;
			end
			code <<= 1;
		end
		nsyms[cls] = k;
	endfunction

	function automatic void put_bits(int v, int n);
		for (int i = n - 1; i >= 0; i--) bitq.insert(bitq.size(), v[i]);
	endfunction

	function automatic void put_sym(int cls, int k);
		put_bits(enc_code[cls][k], enc_len[cls][k]);
	endfunction

	function automatic void flush_bytes();
		logic [7:0] b;
		while (bitq.size() >= 8) begin
			for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
			if ($urandom_range(0, 29) == 0) begin
				send_word(MODE_SCAN, $urandom, $urandom, BYTE_FF);
				send_word(MODE_SCAN, $urandom, $urandom, $urandom_range(1, 255));
			end
			send_word(MODE_SCAN, $urandom, $urandom, b);
			if (b == BYTE_FF) send_word(MODE_SCAN, $urandom, $urandom, 8'h00);
		end
	endfunction

	function automatic void pad_byte();
		while (bitq.size() % 8 != 0) bitq.insert(bitq.size(), 1'b1);
		flush_bytes();
	endfunction

	function automatic void encode_block();
		int k, s, r, sz;
		bit done;
		s = ($urandom_range(0, 99) < 3) ? 12 : $urandom_range(0, 11);
		put_sym(0, s);
		if (s == 12) return;
		put_bits($urandom, s);
		k = 1;
		done = 0;
		while (!done) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				put_sym(1, 0);
				done = 1;
			end else if (r < 14) begin
				put_sym(1, 25);
				flush_bytes();
				return;
			end else begin
				s = $urandom_range(1, 28);
				if (s == 25) s = 24;
				put_sym(1, s);
				sz = ac_list[s][3:0];
				if (sz == 0) begin
					k += 16;
				end else begin
					k += ac_list[s][7:4];
					put_bits($urandom, sz);
					if (k < 64) k++;
				end
				if (k >= 64) done = 1;
			end
		end
		enc_blocks++;
		if (m_ri != 0 && enc_blocks >= m_ri) begin
			enc_blocks = 0;
			pad_byte();
		end
		flush_bytes();
	endfunction

	function automatic void encode_scan(int nblk);
		send_word(MODE_START, $urandom, $urandom, $urandom);
		bitq.delete();
		enc_blocks = 0;
		for (int i = 0; i < nblk; i++) encode_block();
		pad_byte();
	endfunction

	task automatic drain();
		while (pending_q.size() != 0 || s_axis_tvalid || coef_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_interval(logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		m_ri = v;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("== FAIL ==");
			$finish;
		end
		in_fire <= s_axis_tvalid && s_axis_tready;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_fire) begin
				if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					word_s w;
					w = pending_q.pop_front();
					s_axis_tdata <= {w.val, w.idx};
					s_axis_tuser <= {w.cls, w.mode};
					s_axis_tvalid <= 1;
				end else begin
					s_axis_tvalid <= 0;
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (coef_q.size() == 0) begin
				fails++;
				if (fails <= 10) $display("unexpected word kind=%0d pos=%0d coef=%h",
					m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[29:6]);
			end else begin
				coef_s e;
				e = coef_q.pop_front();
				if (e.kind !== m_axis_tuser || e.pos !== m_axis_tdata[5:0] ||
						e.coef !== m_axis_tdata[29:6] || e.last !== m_axis_tlast) begin
					fails++;
					if (fails <= 10)
						$display("mismatch exp k=%0d p=%0d c=%h l=%0d got k=%0d p=%0d c=%h l=%0d",
							e.kind, e.pos, e.coef, e.last, m_axis_tuser,
							m_axis_tdata[5:0], m_axis_tdata[29:6], m_axis_tlast);
				end
			end
		end
	end

	initial begin
		int idle_s [4] = '{0, 83, 0, 26};
		int idle_r [4] = '{0, 0, 83, 26};
		logic [15:0] ri_set [4] = '{16'd0, 16'd1, 16'd3, 16'hffff};
		m_ri = 0;
		m_pred = 0;
		m_rcount = 0;
		m_ff = 0;
		clear_block();
		for (int c = 0; c < 2; c++)
			for (int i = 0; i < 16; i++) m_counts[c][i] = 0;
		build_codes(0);
		build_codes(1);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// tables
		for (int i = 0; i < 16; i++) begin
			send_word(MODE_COUNT, 0, i, dc_cnt[i]);
			send_word(MODE_COUNT, 1, i, ac_cnt[i]);
		end
		for (int i = 0; i < 13; i++) send_word(MODE_SYMBOL, 0, i, dc_list[i]);
		for (int i = 0; i < 29; i++) send_word(MODE_SYMBOL, 1, i, ac_list[i]);
		for (int i = 0; i < 64; i++)
			send_word(MODE_QUANT, $urandom, i,
				(i == 0) ? 8'hff : (i == 5) ? 8'h00 : $urandom_range(1, 255));

		// directed odd cases
		send_word(5, 1, 8'hff, 8'hff);
		send_word(6, 0, 8'h00, 8'h00);
		send_word(7, 1, 8'haa, 8'h55);
		send_word(MODE_COUNT, 1, 8'hff, 8'hff);
		send_word(MODE_COUNT, 0, 8'd16, 8'h80);
		send_word(MODE_COUNT, 0, 8'd15, 8'hff);
		send_word(MODE_COUNT, 0, 8'd15, 8'h00);
		send_word(MODE_QUANT, 0, 8'd64, 8'hff);
		send_word(MODE_QUANT, 1, 8'hc3, 8'h11);
		send_word(MODE_SYMBOL, 1, 8'hff, 8'hf0);
		send_word(MODE_SYMBOL, 0, 8'd200, 8'h0f);
		send_word(MODE_START, 0, 0, 0);
		send_word(MODE_SCAN, 0, 0, BYTE_FF);
		send_word(MODE_SCAN, 0, 0, 8'h5a);
		send_word(MODE_SCAN, 0, 0, BYTE_FF);
		send_word(MODE_SCAN, 0, 0, 8'h00);
		send_word(MODE_SCAN, 1, 8'hff, 8'h00);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle = idle_s[p];
			recv_stall = idle_r[p];
			write_interval(ri_set[p]);
			encode_scan(4);
			if (p == 1) drain();
			encode_scan(3);
			send_word(MODE_SCAN, 0, 0, 8'hff);
			send_word(MODE_SCAN, 0, 0, 8'hff);
			send_word(MODE_SCAN, 0, 0, 8'h00);
			drain();
		end
		send_idle = 0;
		recv_stall = 0;
		write_interval(16'd2);
		encode_scan(2);
		drain();

		if (fails == 0 && coef_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[jpeg_huffman_block_decoder_unit.f]
src/jhd_pkg.sv
src/jhd_ram.sv
src/jhd_out.sv
src/jhd_core.sv
src/jpeg_huffman_block_decoder_unit.sv
tb/sv/tb_jpeg_huffman_block_decoder_unit.sv
